FILE: rtl/core/dsm_pkg.sv
// Package for the DFA stream matcher: sizes, action codes, table entry
// and memory read- and write-request types. No dependencies.
package dsm_pkg;

   localparam int MAX_STATES  = 1024;
   localparam int MAX_SYMBOLS = 32;

   localparam int ACTION_W = 2;
   localparam int STATE_W  = 10;
   localparam int SYM_W    = 5;
   localparam int NEXT_W   = 11;
   localparam int TADDR_W  = STATE_W + SYM_W;
   localparam int TDEPTH   = 2 ** TADDR_W;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WR_TRANS  = 2'd0,
      ACT_WR_ACCEPT = 2'd1,
      ACT_FEED      = 2'd2,
      ACT_FINISH    = 2'd3
   } action_type;

   typedef struct packed {
      logic               dead;
      logic [STATE_W-1:0] state;
   } tentry_type;

   typedef struct packed {
      logic               en;
      logic [TADDR_W-1:0] addr;
      tentry_type         data;
   } trans_wr_type;

   typedef struct packed {
      logic               en;
      logic [STATE_W-1:0] addr;
      logic               flag;
   } acc_wr_type;

   typedef struct packed {
      logic               en;
      logic [STATE_W-1:0] addr;
   } acc_rd_type;

endpackage

FILE: rtl/core/dfa_stream_matcher.sv
// Top level of the DFA stream matcher: transaction pipeline, state tracking
// and result register. Depends on dsm_pkg, dsm_trans_ram, dsm_accept_ram.
//
//   channel  prefix  direction  carries
//   input    req_    in         action, state_index, symbol, next_state,
//                               accept_flag, last
//   result   rsp_    out        accepted, final_state, dead
//
// One transaction per cycle while req_stall is low; the transaction that ends a string
// is registered in stage one and stage two before its result reaches the result register. The
// transition read feeds the next read address directly, so symbols stream at one per cycle while req_stall is low.
// After reset the accept marks are swept clear, all 1024 of them, with req_stall high.
// A held result stalls the input only when a second result is ready behind it.
module dfa_stream_matcher (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dsm_pkg::ACTION_W-1:0]        req_action,
   input  logic [dsm_pkg::STATE_W-1:0]         req_state_index,
   input  logic [dsm_pkg::SYM_W-1:0]           req_symbol,
   input  logic signed [dsm_pkg::NEXT_W-1:0]   req_next_state,
   input  logic                                req_accept_flag,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_accepted,
   output logic [dsm_pkg::STATE_W-1:0]         rsp_final_state,
   output logic                                rsp_dead
);
   import dsm_pkg::*;

   action_type         req_act;
   logic               en;
   logic               accept0;
   logic               sym_ok;
   logic               sidx_ok;
   logic               acc_busy;
   logic               acc_flag;

   logic               state_dead_ff, state_dead_in;
   logic [STATE_W-1:0] state_ff, state_in;

   logic               s1_valid_ff, s1_valid_in;
   action_type         s1_act_ff;
   logic               s1_last_ff;
   logic               s1_deadin_ff;
   logic [STATE_W-1:0] s1_sidx_ff;
   logic               s1_flag_ff;
   logic               s1_sidx_ok_ff;

   logic               s1_feed;
   logic               s1_fin;
   logic               res_dead;
   logic [STATE_W-1:0] res_state;
   logic               cur_dead;
   logic [STATE_W-1:0] cur_state;

   logic               s2_res_ff, s2_res_in;
   logic               s2_dead_ff;
   logic [STATE_W-1:0] s2_state_ff;

   logic               out_valid_ff, out_valid_in;
   logic               out_acc_ff;
   logic               out_dead_ff;
   logic [STATE_W-1:0] out_state_ff;
   logic               out_load;

   trans_wr_type       twr;
   logic               trd_en;
   logic [TADDR_W-1:0] trd_addr;
   tentry_type         trd_data;
   acc_wr_type         awr;
   acc_rd_type         ard;

   assign req_act   = action_type'(req_action);
   assign en        = !(s2_res_ff && out_valid_ff && rsp_stall);
   assign req_stall = acc_busy || !en;
   assign accept0   = req_valid && !req_stall;
   assign sym_ok    = {1'b0, req_symbol} < (SYM_W + 1)'(MAX_SYMBOLS);
   assign sidx_ok   = {1'b0, req_state_index} < (STATE_W + 1)'(MAX_STATES);

   // resolve the transaction in stage one
   assign s1_feed = s1_valid_ff && (s1_act_ff == ACT_FEED);
   assign s1_fin  = s1_valid_ff &&
                    ((s1_act_ff == ACT_FINISH) || (s1_feed && s1_last_ff));

   always_comb begin
      res_dead  = state_dead_ff;
      res_state = state_ff;
      if (s1_feed) begin
         if (s1_deadin_ff || trd_data.dead) begin
            res_dead  = 1'b1;
            res_state = '0;
         end else begin
            res_dead  = 1'b0;
            res_state = trd_data.state;
         end
      end
      cur_dead  = res_dead;
      cur_state = res_state;
      if (s1_fin) begin
         cur_dead  = 1'b0;
         cur_state = '0;
      end
   end

   assign state_dead_in = cur_dead;
   assign state_in      = cur_state;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_dead_ff <= 1'b0;
         state_ff      <= '0;
      end else if (en) begin
         state_dead_ff <= state_dead_in;
         state_ff      <= state_in;
      end
   end

   // stage zero: table write and transition read
   always_comb begin
      twr.en         = accept0 && (req_act == ACT_WR_TRANS) && sidx_ok && sym_ok;
      twr.addr       = {req_state_index, req_symbol};
      twr.data.dead  = req_next_state[NEXT_W-1] ||
                       ({1'b0, req_next_state[NEXT_W-2:0]} >= NEXT_W'(MAX_STATES));
      twr.data.state = req_next_state[STATE_W-1:0];
   end

   assign trd_en   = accept0 && (req_act == ACT_FEED) && !cur_dead && sym_ok;
   assign trd_addr = {cur_state, req_symbol};

   dsm_trans_ram u_trans_ram (
      .clock   (clock),
      .wr      (twr),
      .rd_en   (trd_en),
      .rd_addr (trd_addr),
      .rd_data (trd_data)
   );

   assign s1_valid_in = accept0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept0) begin
         s1_act_ff     <= req_act;
         s1_last_ff    <= req_last;
         s1_deadin_ff  <= cur_dead || !sym_ok;
         s1_sidx_ff    <= req_state_index;
         s1_flag_ff    <= req_accept_flag;
         s1_sidx_ok_ff <= sidx_ok;
      end
   end

   // stage one: accept mark write and lookup
   always_comb begin
      awr.en   = en && s1_valid_ff && (s1_act_ff == ACT_WR_ACCEPT) && s1_sidx_ok_ff;
      awr.addr = s1_sidx_ff;
      awr.flag = s1_flag_ff;
      ard.en   = en && s1_fin;
      ard.addr = res_state;
   end

   dsm_accept_ram u_accept_ram (
      .clock   (clock),
      .reset   (reset),
      .wr      (awr),
      .rd      (ard),
      .rd_flag (acc_flag),
      .busy    (acc_busy)
   );

   assign s2_res_in = s1_fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_res_ff <= 1'b0;
      end else if (en) begin
         s2_res_ff <= s2_res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && s1_fin) begin
         s2_dead_ff  <= res_dead;
         s2_state_ff <= res_state;
      end
   end

   // result register
   assign out_load = en && s2_res_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_acc_ff   <= !s2_dead_ff && acc_flag;
         out_dead_ff  <= s2_dead_ff;
         out_state_ff <= s2_state_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_accepted    = out_acc_ff;
   assign rsp_final_state = out_state_ff;
   assign rsp_dead        = out_dead_ff;

endmodule

FILE: rtl/core/dsm_trans_ram.sv
// Transition table memory: one entry per (state, symbol), one write and one
// registered read per cycle. Depends on dsm_pkg.
module dsm_trans_ram (
   input  logic                          clock,
   input  dsm_pkg::trans_wr_type         wr,
   input  logic                          rd_en,
   input  logic [dsm_pkg::TADDR_W-1:0]   rd_addr,
   output dsm_pkg::tentry_type           rd_data
);
   import dsm_pkg::*;

   tentry_type mem [TDEPTH];
   tentry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/dsm_accept_ram.sv
// Accept mark memory with a clearing sweep after reset (one entry a cycle)
// and a registered read port. Depends on dsm_pkg.
module dsm_accept_ram (
   input  logic                 clock,
   input  logic                 reset,
   input  dsm_pkg::acc_wr_type  wr,
   input  dsm_pkg::acc_rd_type  rd,
   output logic                 rd_flag,
   output logic                 busy
);
   import dsm_pkg::*;

   logic               mem [MAX_STATES];
   logic               rd_flag_ff;
   logic               busy_ff, busy_in;
   logic [STATE_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic               wen;
   logic [STATE_W-1:0] waddr;
   logic               wdata;

   always_comb begin
      busy_in    = busy_ff;
      clr_cnt_in = clr_cnt_ff;
      if (busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == STATE_W'(MAX_STATES - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign wen   = busy_ff | wr.en;
   assign waddr = busy_ff ? clr_cnt_ff : wr.addr;
   assign wdata = busy_ff ? 1'b0 : wr.flag;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_flag_ff <= mem[rd.addr];
      end
   end

   assign rd_flag = rd_flag_ff;
   assign busy    = busy_ff;

endmodule

FILE: sim/tb.sv
// Self-checking testbench for dfa_stream_matcher: builds small automata, streams
// strings through them and compares every verdict against an in-bench DFA model.
// Depends on dsm_pkg and the dfa_stream_matcher RTL.
module tb;
   import dsm_pkg::*;

   typedef struct packed {
      logic               accepted;
      logic [STATE_W-1:0] final_state;
      logic               dead;
   } verdict_type;

   typedef struct {
      action_type                act;
      logic [STATE_W-1:0]        sidx;
      logic [SYM_W-1:0]          sym;
      logic signed [NEXT_W-1:0]  nxt;
      logic                      aflag;
      logic                      last;
      bit                        drain;
      bit                        has_verdict;
      verdict_type               verdict;
   } txn_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [ACTION_W-1:0]        req_action = ACT_FINISH;
   logic [STATE_W-1:0]         req_state_index = '0;
   logic [SYM_W-1:0]           req_symbol = '0;
   logic signed [NEXT_W-1:0]   req_next_state = '0;
   logic                       req_accept_flag = 1'b0;
   logic                       req_last = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_accepted;
   logic [STATE_W-1:0]         rsp_final_state;
   logic                       rsp_dead;

   dfa_stream_matcher DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_state_index (req_state_index),
      .req_symbol      (req_symbol),
      .req_next_state  (req_next_state),
      .req_accept_flag (req_accept_flag),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_final_state (rsp_final_state),
      .rsp_dead        (rsp_dead)
   );

   always #5 clock = ~clock;

   tentry_type          tbl_entry   [TDEPTH];
   bit                  tbl_written [TDEPTH];
   bit                  accept_mark [MAX_STATES];
   bit [STATE_W-1:0]    cur_state;
   bit                  cur_dead;

   txn_type             stream_txns [$];
   verdict_type         verdict_queue [$];
   txn_type             in_flight;
   bit                  drain_next;
   bit                  quiet_tail = 1'b0;
   int                  verdicts_sent;
   int                  verdicts_seen = 0;
   int                  failures;
   int                  gap_left;
   int                  stall_left;

   function automatic bit dfa_advance(input txn_type t, output verdict_type v);
      tentry_type e;
      v = '0;
      case (t.act)
         ACT_WR_TRANS: begin
            e.dead  = (t.nxt < 0);
            e.state = e.dead ? '0 : t.nxt[STATE_W-1:0];
            tbl_entry[{t.sidx, t.sym}]   = e;
            tbl_written[{t.sidx, t.sym}] = 1'b1;
            return 1'b0;
         end
         ACT_WR_ACCEPT: begin
            accept_mark[t.sidx] = t.aflag;
            return 1'b0;
         end
         ACT_FEED: begin
            if (!cur_dead) begin
               e = tbl_entry[{cur_state, t.sym}];
               if (e.dead) begin
                  cur_dead  = 1'b1;
                  cur_state = '0;
               end else begin
                  cur_state = e.state;
               end
            end
            if (!t.last)
               return 1'b0;
         end
         default: ;
      endcase
      v.dead        = cur_dead;
      v.final_state = cur_dead ? '0 : cur_state;
      v.accepted    = !cur_dead && accept_mark[cur_state];
      cur_state     = '0;
      cur_dead      = 1'b0;
      return 1'b1;
   endfunction

   function automatic txn_type make_txn(input action_type act, input logic [STATE_W-1:0] sidx,
                                        input logic [SYM_W-1:0] sym,
                                        input logic signed [NEXT_W-1:0] nxt,
                                        input logic aflag, input logic last);
      txn_type t;
      t = '{act: act, sidx: sidx, sym: sym, nxt: nxt, aflag: aflag, last: last,
            drain: 1'b0, has_verdict: 1'b0, verdict: '0};
      return t;
   endfunction

   function automatic txn_type rand_txn(input action_type act);
      return make_txn(act, STATE_W'($urandom), SYM_W'($urandom), NEXT_W'($urandom),
                      1'($urandom), 1'($urandom));
   endfunction

   // pick a symbol whose table entry exists, so no unwritten entry is ever read
   function automatic bit pick_symbol(output logic [SYM_W-1:0] s);
      int cand [$];
      s = SYM_W'($urandom);
      if (cur_dead)
         return 1'b1;
      for (int i = 0; i < MAX_SYMBOLS; i++)
         if (tbl_written[{cur_state, SYM_W'(i)}])
            cand.push_back(i);
      if (cand.size() == 0)
         return 1'b0;
      s = SYM_W'(cand[$urandom_range(0, cand.size() - 1)]);
      return 1'b1;
   endfunction

   task automatic queue_txn(input txn_type t);
      verdict_type v;
      t.has_verdict = dfa_advance(t, v);
      t.verdict     = v;
      t.drain       = drain_next;
      drain_next    = 1'b0;
      stream_txns.push_back(t);
   endtask

   task automatic queue_string(input int len);
      txn_type t;
      int      k;
      bit      by_finish;
      by_finish = ($urandom_range(0, 3) == 0);
      for (k = 0; k < len; k++) begin
         t = rand_txn(ACT_FEED);
         if (!pick_symbol(t.sym))
            break;
         t.last = !by_finish && (k == len - 1);
         queue_txn(t);
      end
      if (k < len || len == 0 || by_finish)
         queue_txn(rand_txn(ACT_FINISH));
   endtask

   task automatic queue_episode();
      logic [STATE_W-1:0] states [$];
      txn_type            t;
      states.push_back('0);
      repeat ($urandom_range(1, 5))
         states.push_back(STATE_W'($urandom));
      foreach (states[i]) begin
         repeat ($urandom_range(1, 4)) begin
            t = rand_txn(ACT_WR_TRANS);
            t.sidx = states[i];
            if ($urandom_range(0, 5) != 0)
               t.nxt = {1'b0, states[$urandom_range(0, states.size() - 1)]};
            queue_txn(t);
         end
         t = rand_txn(ACT_WR_ACCEPT);
         t.sidx = states[i];
         queue_txn(t);
      end
      repeat ($urandom_range(1, 5))
         queue_string($urandom_range(0, 8));
   endtask

   initial begin
      txn_type t;
      queue_txn(make_txn(ACT_FINISH, 5, 3, 7, 1'b1, 1'b1));
      queue_txn(make_txn(ACT_WR_ACCEPT, 0, 0, 0, 1'b1, 1'b1));
      queue_txn(make_txn(ACT_FINISH, 0, 0, 0, 1'b0, 1'b0));
      queue_txn(make_txn(ACT_WR_TRANS, 0, 31, 1023, 1'b0, 1'b1));
      queue_txn(make_txn(ACT_WR_TRANS, 1023, 0, -1, 1'b0, 1'b0));
      queue_txn(make_txn(ACT_WR_TRANS, 1023, 5, -1024, 1'b1, 1'b0));
      queue_txn(make_txn(ACT_WR_TRANS, 1023, 31, 0, 1'b1, 1'b0));
      queue_txn(make_txn(ACT_WR_ACCEPT, 1023, 0, 0, 1'b1, 1'b0));
      queue_txn(make_txn(ACT_FEED, 0, 31, 0, 1'b0, 1'b0));
      queue_txn(make_txn(ACT_FINISH, 1023, 31, -1, 1'b1, 1'b1));
      queue_txn(make_txn(ACT_FEED, 1023, 31, 0, 1'b1, 1'b0));
      queue_txn(make_txn(ACT_FEED, 0, 31, 0, 1'b0, 1'b0));
      queue_txn(make_txn(ACT_FEED, 0, 31, 0, 1'b0, 1'b1));
      queue_txn(make_txn(ACT_FEED, 0, 31, 0, 1'b0, 1'b0));
      queue_txn(make_txn(ACT_FEED, 0, 0, 0, 1'b0, 1'b0));
      queue_txn(make_txn(ACT_FEED, 0, 17, 0, 1'b0, 1'b1));
      queue_txn(make_txn(ACT_FEED, 0, 31, 0, 1'b0, 1'b0));
      queue_txn(make_txn(ACT_FEED, 0, 5, 0, 1'b0, 1'b1));
      queue_txn(make_txn(ACT_WR_ACCEPT, 1023, 31, 0, 1'b0, 1'b1));
      queue_txn(make_txn(ACT_FEED, 0, 31, 0, 1'b0, 1'b1));
      queue_txn(make_txn(ACT_FEED, 0, 31, 0, 1'b0, 1'b0));
      queue_txn(make_txn(ACT_FEED, 0, 0, 0, 1'b0, 1'b0));
      queue_txn(make_txn(ACT_FINISH, 0, 0, 0, 1'b0, 1'b0));
      drain_next = 1'b1;
      while (stream_txns.size() < 1475) begin
         if ($urandom_range(0, 14) == 0)
            drain_next = 1'b1;
         if ($urandom_range(0, 6) != 0) begin
            queue_episode();
         end else begin
            repeat ($urandom_range(1, 8)) begin
               t = rand_txn(action_type'($urandom_range(0, 3)));
               if (t.act == ACT_FEED && !pick_symbol(t.sym))
                  t.act = ACT_FINISH;
               queue_txn(t);
            end
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (stream_txns.size() != 0 || req_valid || verdict_queue.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0 && verdict_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall && in_flight.has_verdict) begin
            verdict_queue.push_back(in_flight.verdict);
            verdicts_sent++;
         end
         quiet_tail <= (stream_txns.size() < 150);
         if (!req_valid || !req_stall) begin
            if (gap_left == 0 && !quiet_tail && $urandom_range(0, 4) == 0)
               gap_left = $urandom_range(1, 17);
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (stream_txns.size() == 0 ||
                         (stream_txns[0].drain && verdicts_seen != verdicts_sent)) begin
               req_valid <= 1'b0;
            end else begin
               in_flight = stream_txns.pop_front();
               req_valid       <= 1'b1;
               req_action      <= in_flight.act;
               req_state_index <= in_flight.sidx;
               req_symbol      <= in_flight.sym;
               req_next_state  <= in_flight.nxt;
               req_accept_flag <= in_flight.aflag;
               req_last        <= in_flight.last;
            end
         end
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            verdicts_seen <= verdicts_seen + 1;
            if (verdict_queue.size() == 0) begin
               $error("unexpected result: accepted %0d final_state %0d dead %0d",
                      rsp_accepted, rsp_final_state, rsp_dead);
               failures++;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_accepted !== want.accepted) begin
                  $error("accepted: expected %0d, actual %0d", want.accepted, rsp_accepted);
                  failures++;
               end
               if (rsp_final_state !== want.final_state) begin
                  $error("final_state: expected %0d, actual %0d",
                         want.final_state, rsp_final_state);
                  failures++;
               end
               if (rsp_dead !== want.dead) begin
                  $error("dead: expected %0d, actual %0d", want.dead, rsp_dead);
                  failures++;
               end
            end
         end
         if (stall_left == 0 && !quiet_tail && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 17);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

endmodule
